FILE: rtl/core/price_level_book_unit_macros.svh
// shared assertion macros for the price level book
`ifndef PRICE_LEVEL_BOOK_UNIT_MACROS_SVH
`define PRICE_LEVEL_BOOK_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define PLB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plb assertion failed");

// next-cycle implication, held off during reset
`define PLB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plb assertion failed");

`endif

FILE: rtl/core/plb_pkg.sv
package plb_pkg;

    localparam int DEPTH_BITS = 38;
    localparam int CFG_BITS   = 7;
    localparam logic [CFG_BITS-1:0] DEPTH_LEVELS_RST = 7'd5;

    localparam logic FN_UPDATE = 1'b0;
    localparam logic FN_CLEAR  = 1'b1;
    localparam logic SIDE_BID  = 1'b0;
    localparam logic SIDE_ASK  = 1'b1;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_DROP = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic        func;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
    } t_in_item;

    typedef struct packed {
        logic                    bid_valid;
        logic [31:0]             bid_price;
        logic [31:0]             bid_quantity;
        logic                    ask_valid;
        logic [31:0]             ask_price;
        logic [31:0]             ask_quantity;
        logic [DEPTH_BITS-1:0]   bid_depth;
        logic [DEPTH_BITS-1:0]   ask_depth;
        logic signed [15:0]      imbalance_q15;
        logic [1:0]              status;
    } t_out_item;

endpackage

FILE: rtl/core/plb_ram.sv
module plb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/price_level_book_unit.sv
// channel | dir | handshake                | payload
// in      | in  | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
// out     | out | o_out_valid / i_out_ready| o_out_data (t_out_item)
// cfg     | in  | i_cfg_valid / o_cfg_ready| i_cfg_data (depth_levels)
// one item at a time; an update scans each level before its place, moves each level that
// must shift to open or close a gap, sums the levels (max of both depths, at least one)
// and runs the imbalance divide (skipped with both sides empty) before its result is out;
// each side table is a ram with registered read, so each access has a read state and a use state.
// the output register frees the input; a further result stalls until the held one is taken.
// synchronous active-low reset empties both sides; table contents are not cleared.
module price_level_book_unit #(
    parameter int LEVELS     = 64,
    parameter int PRICE_BITS = 32,
    parameter int QTY_BITS   = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  plb_pkg::t_in_item        i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output plb_pkg::t_out_item       o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [plb_pkg::CFG_BITS-1:0] i_cfg_data
);
    import plb_pkg::*;
    `include "price_level_book_unit_macros.svh"

    localparam int AW = $clog2(LEVELS);
    localparam int CW = $clog2(LEVELS + 1);
    localparam int LW = (CW > CFG_BITS) ? CW : CFG_BITS;
    localparam int EW = PRICE_BITS + QTY_BITS;
    localparam int RW = QTY_BITS + 2;
    localparam logic [CW-1:0] LEVELS_C = CW'(LEVELS);
    localparam logic [CW-1:0] LAST_C   = CW'(LEVELS - 1);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_SRCH_RD  = 12'b000000000010,
        S_SRCH_CHK = 12'b000000000100,
        S_DECIDE   = 12'b000000001000,
        S_MV_RD    = 12'b000000010000,
        S_MV_WR    = 12'b000000100000,
        S_PUT      = 12'b000001000000,
        S_SUM_RD   = 12'b000010000000,
        S_SUM_ACC  = 12'b000100000000,
        S_DIV_INIT = 12'b001000000000,
        S_DIV      = 12'b010000000000,
        S_OUT      = 12'b100000000000
    } t_state;

    t_state r_state;
    logic                  r_side, r_hit, r_up, r_neg;
    logic [PRICE_BITS-1:0] r_price;
    logic [QTY_BITS-1:0]   r_qty;
    logic [CW-1:0]         r_k, r_i, r_n, r_cnt_b, r_cnt_a;
    logic [1:0]            r_status;
    logic [DEPTH_BITS-1:0] r_sum_b, r_sum_a;
    logic [PRICE_BITS-1:0] r_best_bp, r_best_ap;
    logic [QTY_BITS-1:0]   r_best_bq, r_best_aq;
    logic [RW-1:0]         r_rem;
    logic [QTY_BITS:0]     r_den;
    logic [15:0]           r_quo;
    logic [3:0]            r_step;
    logic [CFG_BITS-1:0]   r_depth;
    t_out_item             r_out;
    logic                  r_out_valid;

    // ram ports
    logic [AW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] wr_data, rdata_b, rdata_a, rdata;
    logic          we_b, we_a;

    plb_ram #(.WIDTH(EW), .DEPTH(LEVELS)) u_bid_ram (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(wr_addr), .i_wdata(wr_data),
        .i_raddr(rd_addr), .o_rdata(rdata_b)
    );
    plb_ram #(.WIDTH(EW), .DEPTH(LEVELS)) u_ask_ram (
        .i_clk(i_clk), .i_we(we_a), .i_waddr(wr_addr), .i_wdata(wr_data),
        .i_raddr(rd_addr), .o_rdata(rdata_a)
    );

    // input field fitting to storage widths
    logic [63:0] in_price64, in_qty64;
    assign in_price64 = 64'(i_in_data.price);
    assign in_qty64   = 64'(i_in_data.quantity);

    logic [CW-1:0]         cur_cnt;
    logic [PRICE_BITS-1:0] rd_price;
    logic                  better;
    assign cur_cnt  = r_side ? r_cnt_a : r_cnt_b;
    assign rdata    = r_side ? rdata_a : rdata_b;
    assign rd_price = rdata[EW-1:QTY_BITS];
    assign better   = r_side ? (rd_price < r_price) : (rd_price > r_price);

    // depth limits per side
    logic [LW-1:0] dep_l, cnt_b_l, cnt_a_l, lim_b, lim_a, lim_max, k_l;
    assign dep_l   = LW'(r_depth);
    assign cnt_b_l = LW'(r_cnt_b);
    assign cnt_a_l = LW'(r_cnt_a);
    assign k_l     = LW'(r_k);
    assign lim_b   = (dep_l < cnt_b_l) ? dep_l : cnt_b_l;
    assign lim_a   = (dep_l < cnt_a_l) ? dep_l : cnt_a_l;
    always_comb begin
        lim_max = (lim_b > lim_a) ? lim_b : lim_a;
        if (lim_max == '0) begin
            lim_max = LW'(1);
        end
    end

    logic [63:0] qb64, qa64;
    assign qb64 = 64'(rdata_b[QTY_BITS-1:0]);
    assign qa64 = 64'(rdata_a[QTY_BITS-1:0]);

    // top-of-book quantities
    logic [QTY_BITS-1:0] bq, aq;
    assign bq = (r_cnt_b != '0) ? r_best_bq : '0;
    assign aq = (r_cnt_a != '0) ? r_best_aq : '0;

    // divide step
    logic [RW-1:0] den_w, diff;
    logic          ge;
    assign den_w = RW'(r_den);
    assign ge    = (r_rem >= den_w);
    assign diff  = r_rem - den_w;

    // output formatting
    logic [63:0] bp64, ap64, bq64o, aq64o;
    logic [15:0] q_pos, q_neg;
    assign bp64  = 64'((r_cnt_b != '0) ? r_best_bp : '0);
    assign ap64  = 64'((r_cnt_a != '0) ? r_best_ap : '0);
    assign bq64o = 64'(bq);
    assign aq64o = 64'(aq);
    assign q_pos = (r_quo > 16'd32767) ? 16'd32767 : r_quo;
    assign q_neg = (r_quo > 16'd32768) ? 16'd32768 : r_quo;

    always_comb begin
        rd_addr = r_k[AW-1:0];
        wr_addr = r_k[AW-1:0];
        wr_data = rdata;
        we_b    = 1'b0;
        we_a    = 1'b0;
        case (r_state)
            S_MV_RD: begin
                rd_addr = r_up ? AW'(r_k - CW'(1)) : AW'(r_k + CW'(1));
            end
            S_MV_WR: begin
                we_b = (r_side == SIDE_BID);
                we_a = (r_side == SIDE_ASK);
            end
            S_PUT: begin
                wr_addr = r_i[AW-1:0];
                wr_data = {r_price, r_qty};
                we_b    = (r_side == SIDE_BID);
                we_a    = (r_side == SIDE_ASK);
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_b     <= '0;
            r_cnt_a     <= '0;
            r_depth     <= DEPTH_LEVELS_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_depth <= i_cfg_data;
            end
            // a new result in S_OUT takes over the output register itself
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_side   <= i_in_data.side;
                        r_price  <= in_price64[PRICE_BITS-1:0];
                        r_qty    <= in_qty64[QTY_BITS-1:0];
                        r_k      <= '0;
                        r_hit    <= 1'b0;
                        r_status <= ST_DONE;
                        r_sum_b  <= '0;
                        r_sum_a  <= '0;
                        if (i_in_data.func == FN_CLEAR) begin
                            r_cnt_b <= '0;
                            r_cnt_a <= '0;
                            r_state <= S_SUM_RD;
                        end else begin
                            r_state <= S_SRCH_RD;
                        end
                    end
                end
                S_SRCH_RD: begin
                    r_state <= (r_k < cur_cnt) ? S_SRCH_CHK : S_DECIDE;
                end
                S_SRCH_CHK: begin
                    if (better) begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_SRCH_RD;
                    end else begin
                        r_hit   <= (rd_price == r_price);
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_i <= r_k;
                    if (r_hit) begin
                        if (r_qty == '0) begin
                            r_up    <= 1'b0;
                            r_state <= S_MV_RD;
                        end else begin
                            r_state <= S_PUT;
                        end
                    end else if (r_qty == '0) begin
                        r_k     <= '0;
                        r_state <= S_SUM_RD;
                    end else if (cur_cnt >= LEVELS_C) begin
                        if (r_k >= LEVELS_C) begin
                            r_status <= ST_FULL;
                            r_k      <= '0;
                            r_state  <= S_SUM_RD;
                        end else begin
                            // worst level falls off the end
                            r_status <= ST_DROP;
                            r_n      <= LAST_C;
                            r_k      <= LAST_C;
                            r_up     <= 1'b1;
                            r_state  <= S_MV_RD;
                        end
                    end else begin
                        r_n     <= cur_cnt;
                        r_k     <= cur_cnt;
                        r_up    <= 1'b1;
                        r_state <= S_MV_RD;
                    end
                end
                S_MV_RD: begin
                    if (r_up) begin
                        r_state <= (r_k > r_i) ? S_MV_WR : S_PUT;
                    end else if (r_k + CW'(1) < cur_cnt) begin
                        r_state <= S_MV_WR;
                    end else begin
                        if (r_side == SIDE_ASK) begin
                            r_cnt_a <= r_cnt_a - CW'(1);
                        end else begin
                            r_cnt_b <= r_cnt_b - CW'(1);
                        end
                        r_k     <= '0;
                        r_state <= S_SUM_RD;
                    end
                end
                S_MV_WR: begin
                    r_k     <= r_up ? (r_k - CW'(1)) : (r_k + CW'(1));
                    r_state <= S_MV_RD;
                end
                S_PUT: begin
                    if (!r_hit) begin
                        if (r_side == SIDE_ASK) begin
                            r_cnt_a <= r_n + CW'(1);
                        end else begin
                            r_cnt_b <= r_n + CW'(1);
                        end
                    end
                    r_k     <= '0;
                    r_state <= S_SUM_RD;
                end
                S_SUM_RD: begin
                    r_state <= S_SUM_ACC;
                end
                S_SUM_ACC: begin
                    if (k_l < lim_b) begin
                        r_sum_b <= r_sum_b + qb64[DEPTH_BITS-1:0];
                    end
                    if (k_l < lim_a) begin
                        r_sum_a <= r_sum_a + qa64[DEPTH_BITS-1:0];
                    end
                    if (r_k == '0) begin
                        r_best_bp <= rdata_b[EW-1:QTY_BITS];
                        r_best_bq <= rdata_b[QTY_BITS-1:0];
                        r_best_ap <= rdata_a[EW-1:QTY_BITS];
                        r_best_aq <= rdata_a[QTY_BITS-1:0];
                    end
                    if (k_l + LW'(1) < lim_max) begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_SUM_RD;
                    end else begin
                        r_state <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT: begin
                    r_den  <= {1'b0, bq} + {1'b0, aq};
                    r_neg  <= (aq > bq);
                    r_rem  <= RW'((aq > bq) ? (aq - bq) : (bq - aq));
                    r_quo  <= '0;
                    r_step <= '0;
                    // both sides empty gives zero imbalance
                    r_state <= ((bq == '0) && (aq == '0)) ? S_OUT : S_DIV;
                end
                S_DIV: begin
                    r_quo  <= {r_quo[14:0], ge};
                    r_rem  <= {(ge ? diff[RW-2:0] : r_rem[RW-2:0]), 1'b0};
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd15) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.bid_valid     <= (r_cnt_b != '0);
                        r_out.bid_price     <= bp64[31:0];
                        r_out.bid_quantity  <= bq64o[31:0];
                        r_out.ask_valid     <= (r_cnt_a != '0);
                        r_out.ask_price     <= ap64[31:0];
                        r_out.ask_quantity  <= aq64o[31:0];
                        r_out.bid_depth     <= r_sum_b;
                        r_out.ask_depth     <= r_sum_a;
                        r_out.imbalance_q15 <= r_neg ? $signed(~q_neg + 16'd1)
                                                     : $signed(q_pos);
                        r_out.status        <= r_status;
                        r_out_valid         <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `PLB_ASSERT_IMP(a_cnt_b_max, i_clk, i_rst_n, 1'b1, r_cnt_b <= LEVELS_C)
    `PLB_ASSERT_IMP(a_cnt_a_max, i_clk, i_rst_n, 1'b1, r_cnt_a <= LEVELS_C)
    `PLB_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `PLB_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_den != '0)
    `PLB_ASSERT_IMP(a_one_writer, i_clk, i_rst_n, we_b || we_a, !(we_b && we_a))

endmodule
